[hw/rtl/lcrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrm_pkg
// Shared types and constants of the leader clustering running-mean unit.
// ----------------------------------------------------------------------------
package lcrm_pkg;

    localparam int NUM_CLUSTERS = 16;
    localparam int COMP_W       = 16;
    localparam int CNT_W        = 16;
    localparam int NUM_COMP     = 6;
    localparam int IDX_W        = $clog2(NUM_CLUSTERS);
    localparam int USED_W       = $clog2(NUM_CLUSTERS + 1);
    localparam int MEM_DEPTH    = NUM_CLUSTERS * NUM_COMP;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);
    localparam int CI_W         = $clog2(NUM_COMP);
    localparam int THR_W        = 23;
    localparam int THR_SHIFT    = 12;
    localparam int SUM_W        = 2 * (COMP_W + 1) + 1;
    localparam int DEN_W        = CNT_W + 1;
    localparam int DVD_W        = COMP_W + CNT_W + 3;
    localparam int QUO_W        = COMP_W;
    localparam int PROD_W       = 2 * (DEN_W + 1);
    localparam int IN_DATA_W    = 96;
    localparam int OUT_DATA_W   = 128;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(410);
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_D_RD,
        ST_D_MUL,
        ST_D_ACC,
        ST_D_CMP,
        ST_B_RD,
        ST_B_MUL,
        ST_B_DIV,
        ST_B_WR,
        ST_NEW,
        ST_S_LOOP,
        ST_M_RD,
        ST_M_CAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hw/rtl/lcrm_mean_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrm_mean_mem
// Cluster mean storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lcrm_mean_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [lcrm_pkg::ADDR_W-1:0] waddr,
    input  logic [lcrm_pkg::COMP_W-1:0] wdata,
    input  logic [lcrm_pkg::ADDR_W-1:0] raddr,
    output logic [lcrm_pkg::COMP_W-1:0] rdata
);
    import lcrm_pkg::*;

    logic [COMP_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/lcrm_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrm_divider
// Restoring divider, one quotient bit per cycle; quotient known < 2^QUO_W.
// ----------------------------------------------------------------------------
module lcrm_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  lcrm_pkg::div_req_t req,
    output lcrm_pkg::div_rsp_t rsp
);
    import lcrm_pkg::*;

    localparam int REM_W = DVD_W - QUO_W;
    localparam int CNT_BITS = $clog2(QUO_W + 1);

    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    q_reg, q_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [REM_W:0]      trial;

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg, q_reg[QUO_W-1]};
        if (req.start)
        begin
            rem_next = req.dividend[DVD_W-1:QUO_W];
            q_next   = req.dividend[QUO_W-1:0];
            den_next = req.divisor;
            cnt_next = CNT_BITS'(QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= (REM_W + 1)'(den_reg))
            begin
                rem_next = REM_W'(trial - (REM_W + 1)'(den_reg));
                q_next   = {q_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = REM_W'(trial);
                q_next   = {q_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.quotient = q_reg;

endmodule

[hw/rtl/leader_cluster_running_mean_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leader_cluster_running_mean_unit
// Online leader clustering with rounded running means, one shared multiplier
// and one serial divider stepped by a sequencer.
// ----------------------------------------------------------------------------
//  port group    dir  content
//  s_axis_*      in   sample beat: tdata components, tuser operation
//  m_axis_*      out  largest-cluster report beat
//  cfg_*         in   merge_threshold_sq write
//
//  Add: a distance pass over each held cluster, a rounded mean update of
//  each matching cluster through the divider, a new cluster if none matched,
//  then a largest-cluster scan and the report. Clear: empties the table and
//  reports. s_axis_tready is high only between items.
//  A waiting report holds the sequencer in ST_DONE; no input beat is taken
//  until it leaves.
//  Reset clears the cluster count, loads THR_RESET; stores need no clearing.
// ----------------------------------------------------------------------------
module leader_cluster_running_mean_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_c0 .. sample_c5, 16 bits each
    input  logic [lcrm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // best_index, best_count, best_mean_c0..c5, clusters_used,
    // joined_existing, sample_dropped, zero pad
    output logic [lcrm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [lcrm_pkg::THR_W-1:0]          cfg_wdata
);
    import lcrm_pkg::*;

    state_t state_reg, state_next;

    logic [THR_W-1:0]           thr_reg;
    logic                       op_reg;
    logic signed [COMP_W-1:0]   x_reg [NUM_COMP];
    logic [USED_W-1:0]          used_reg, used_next;
    logic [USED_W-1:0]          k_reg, k_next;
    logic [CI_W-1:0]            i_reg, i_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic                       joined_reg, joined_next;
    logic                       dropped_reg, dropped_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]           best_reg, best_next;
    logic [CNT_W-1:0]           bcnt_reg, bcnt_next;
    logic [COMP_W-1:0]          bm_reg [NUM_COMP];
    logic [CNT_W-1:0]           count_mem [NUM_CLUSTERS];
    logic                       neg_reg, neg_next;
    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_reg;

    logic signed [PROD_W/2-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod_reg;

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
    logic [COMP_W-1:0]          mem_wdata, mem_rdata;

    div_req_t                   dreq;
    div_rsp_t                   drsp;

    logic                       cnt_we;
    logic [IDX_W-1:0]           cnt_waddr;
    logic [CNT_W-1:0]           cnt_wdata;
    logic                       bm_we;
    logic                       load_out;

    logic signed [DVD_W-1:0]    num;
    logic [DVD_W-1:0]           mag;
    logic [DEN_W-1:0]           den;
    logic [QUO_W-1:0]           qsigned;
    logic [ADDR_W-1:0]          base_k, base_best;
    logic [SUM_W-1:0]           limit;

    lcrm_mean_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lcrm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign base_k    = ADDR_W'(k_reg[IDX_W-1:0]) * ADDR_W'(NUM_COMP);
    assign base_best = ADDR_W'(best_reg) * ADDR_W'(NUM_COMP);
    assign limit     = SUM_W'(thr_reg) << THR_SHIFT;
    assign den       = DEN_W'(cnt_reg) + 1'b1;
    assign num       = DVD_W'(prod_reg) + DVD_W'(x_reg[i_reg]);
    assign mag       = num[DVD_W-1] ? DVD_W'(-num) : DVD_W'(num);
    assign qsigned   = neg_reg ? QUO_W'(-drsp.quotient) : drsp.quotient;

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        sum_next     = sum_reg;
        joined_next  = joined_reg;
        dropped_next = dropped_reg;
        cnt_next     = cnt_reg;
        best_next    = best_reg;
        bcnt_next    = bcnt_reg;
        neg_next     = neg_reg;
        mem_we       = 1'b0;
        mem_waddr    = base_k + ADDR_W'(i_reg);
        mem_wdata    = qsigned;
        mem_raddr    = base_k + ADDR_W'(i_reg);
        mul_a        = (PROD_W/2)'($signed(mem_rdata)) - (PROD_W/2)'(x_reg[i_reg]);
        mul_b        = mul_a;
        dreq.start    = 1'b0;
        dreq.dividend = mag + DVD_W'(den >> 1);
        dreq.divisor  = den;
        cnt_we       = 1'b0;
        cnt_waddr    = k_reg[IDX_W-1:0];
        cnt_wdata    = cnt_reg + 1'b1;
        bm_we        = 1'b0;
        load_out     = 1'b0;
        s_axis_tready = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                k_next       = '0;
                joined_next  = 1'b0;
                dropped_next = 1'b0;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == OP_CLEAR)
                    begin
                        used_next  = '0;
                        state_next = ST_S_LOOP;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                    best_next = '0;
                    bcnt_next = '0;
                end
            end
            ST_CHECK:
            begin
                i_next   = '0;
                sum_next = '0;
                if (k_reg == used_reg)
                begin
                    state_next = ST_NEW;
                end
                else
                begin
                    state_next = ST_D_RD;
                end
            end
            ST_D_RD:
            begin
                state_next = ST_D_MUL;
            end
            ST_D_MUL:
            begin
                state_next = ST_D_ACC;
            end
            ST_D_ACC:
            begin
                sum_next = sum_reg + SUM_W'(prod_reg);
                if (i_reg == CI_W'(NUM_COMP - 1))
                begin
                    state_next = ST_D_CMP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_D_RD;
                end
            end
            ST_D_CMP:
            begin
                i_next = '0;
                if (sum_reg < limit)
                begin
                    joined_next = 1'b1;
                    cnt_next    = count_mem[k_reg[IDX_W-1:0]];
                    state_next  = ST_B_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_B_RD:
            begin
                state_next = ST_B_MUL;
            end
            ST_B_MUL:
            begin
                mul_a      = (PROD_W/2)'($signed(mem_rdata));
                mul_b      = (PROD_W/2)'(den);
                mul_b      = mul_b - 1'b1;
                state_next = ST_B_DIV;
            end
            ST_B_DIV:
            begin
                dreq.start = 1'b1;
                neg_next   = num[DVD_W-1];
                state_next = ST_B_WR;
            end
            ST_B_WR:
            begin
                if (!drsp.busy)
                begin
                    mem_we = 1'b1;
                    if (i_reg == CI_W'(NUM_COMP - 1))
                    begin
                        cnt_we     = (cnt_reg != {CNT_W{1'b1}});
                        k_next     = k_reg + 1'b1;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_B_RD;
                    end
                end
            end
            ST_NEW:
            begin
                if (joined_reg)
                begin
                    k_next     = '0;
                    state_next = ST_S_LOOP;
                end
                else if (used_reg == USED_W'(NUM_CLUSTERS))
                begin
                    dropped_next = 1'b1;
                    k_next       = '0;
                    state_next   = ST_S_LOOP;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(used_reg[IDX_W-1:0]) * ADDR_W'(NUM_COMP)
                                + ADDR_W'(i_reg);
                    mem_wdata = x_reg[i_reg];
                    if (i_reg == CI_W'(NUM_COMP - 1))
                    begin
                        cnt_we    = 1'b1;
                        cnt_waddr = used_reg[IDX_W-1:0];
                        cnt_wdata = CNT_W'(1);
                        used_next = used_reg + 1'b1;
                        k_next    = '0;
                        state_next = ST_S_LOOP;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            ST_S_LOOP:
            begin
                i_next = '0;
                if (k_reg == used_reg)
                begin
                    state_next = ST_M_RD;
                end
                else
                begin
                    if (count_mem[k_reg[IDX_W-1:0]] > bcnt_reg)
                    begin
                        bcnt_next = count_mem[k_reg[IDX_W-1:0]];
                        best_next = k_reg[IDX_W-1:0];
                    end
                    k_next = k_reg + 1'b1;
                end
            end
            ST_M_RD:
            begin
                mem_raddr  = base_best + ADDR_W'(i_reg);
                state_next = ST_M_CAP;
            end
            ST_M_CAP:
            begin
                bm_we = 1'b1;
                if (i_reg == CI_W'(NUM_COMP - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_M_RD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        i_reg       <= i_next;
        sum_reg     <= sum_next;
        joined_reg  <= joined_next;
        dropped_reg <= dropped_next;
        cnt_reg     <= cnt_next;
        best_reg    <= best_next;
        bcnt_reg    <= bcnt_next;
        neg_reg     <= neg_next;
        prod_reg    <= mul_a * mul_b;
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            op_reg <= s_axis_tuser;
            for (int c = 0; c < NUM_COMP; c++)
            begin
                x_reg[c] <= s_axis_tdata[c*COMP_W +: COMP_W];
            end
        end
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (bm_we)
        begin
            bm_reg[i_reg] <= (used_reg != '0) ? mem_rdata : '0;
        end
        if (load_out)
        begin
            out_reg <= {5'b0, dropped_reg, joined_reg, used_reg,
                        bm_reg[5], bm_reg[4], bm_reg[3], bm_reg[2], bm_reg[1], bm_reg[0],
                        bcnt_reg, best_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

`ifndef NO_ASSERTIONS
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(NUM_CLUSTERS))
        else $error("cluster count out of range");
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && dropped_reg |-> used_reg == USED_W'(NUM_CLUSTERS) && !joined_reg)
        else $error("drop without full table");
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && op_reg == OP_CLEAR |-> used_reg == '0 && bcnt_reg == '0)
        else $error("clear left clusters");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.busy |-> state_reg == ST_B_WR)
        else $error("divider busy outside write wait");
`endif

endmodule
